[rtl/scc_pkg.sv]
`default_nettype none
package scc_pkg;

	localparam logic [2:0] PH_DOLLAR   = 3'd0;
	localparam logic [2:0] PH_BODY     = 3'd1;
	localparam logic [2:0] PH_HEX_HI   = 3'd2;
	localparam logic [2:0] PH_HEX_LO   = 3'd3;
	localparam logic [2:0] PH_TAIL     = 3'd4;
	localparam logic [2:0] PH_AFTER_CR = 3'd5;
	localparam logic [2:0] PH_AFTER_LF = 3'd6;
	localparam logic [2:0] PH_SKIP     = 3'd7;

	localparam logic [2:0] FC_NONE   = 3'd0;
	localparam logic [2:0] FC_DOLLAR = 3'd1;
	localparam logic [2:0] FC_STAR   = 3'd2;
	localparam logic [2:0] FC_HEX    = 3'd3;
	localparam logic [2:0] FC_ENDING = 3'd4;
	localparam logic [2:0] FC_CRC    = 3'd5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CRC_POLY  = 8'h07;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] crc;
		logic [7:0] rx;
		logic [2:0] fault;
	} state_t;

	typedef struct packed {
		logic       frame_ok;
		logic [7:0] crc_received;
		logic [7:0] crc_computed;
		logic [2:0] fault_cause;
	} res_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
			else c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
		logic [4:0] v;
		v = 5'h10;
		if (ch inside {[8'h30:8'h39]}) v = {1'b0, 4'(ch - 8'h30)};
		else if (ch inside {[8'h41:8'h46]}) v = {1'b0, 4'(ch - 8'h37)};
		else if (ch inside {[8'h61:8'h66]}) v = {1'b0, 4'(ch - 8'h57)};
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/scc_step.sv]
`default_nettype none
module scc_step import scc_pkg::*; (
	input  wire state_t     cur,
	input  wire logic [7:0] byte_in,
	input  wire logic       last_byte,
	output state_t          nxt,
	output res_t            res
);

	always_comb begin
		state_t     s;
		logic [4:0] nib;
		logic [2:0] cause;
		s = cur;
		nib = hex_nibble(byte_in);
		case (cur.phase)
			PH_DOLLAR: begin
				if (byte_in == CH_DOLLAR) s.phase = PH_BODY;
				else begin
					if (s.fault == FC_NONE) s.fault = FC_DOLLAR;
					s.phase = PH_SKIP;
				end
			end
			PH_BODY: begin
				if (byte_in == CH_STAR) s.phase = PH_HEX_HI;
				else s.crc = crc8_byte(cur.crc, byte_in);
			end
			PH_HEX_HI: begin
				if (!nib[4]) begin
					s.rx = {nib[3:0], 4'h0};
					s.phase = PH_HEX_LO;
				end else begin
					if (s.fault == FC_NONE) s.fault = FC_HEX;
					s.phase = PH_SKIP;
				end
			end
			PH_HEX_LO: begin
				if (!nib[4]) begin
					s.rx = {cur.rx[7:4], nib[3:0]};
					s.phase = PH_TAIL;
				end else begin
					if (s.fault == FC_NONE) s.fault = FC_HEX;
					s.phase = PH_SKIP;
				end
			end
			PH_TAIL: begin
				if (byte_in == CH_CR) s.phase = PH_AFTER_CR;
				else if (byte_in == CH_LF) s.phase = PH_AFTER_LF;
				else begin
					if (s.fault == FC_NONE) s.fault = FC_ENDING;
					s.phase = PH_SKIP;
				end
			end
			PH_AFTER_CR: begin
				if (byte_in == CH_LF) s.phase = PH_AFTER_LF;
				else begin
					if (s.fault == FC_NONE) s.fault = FC_ENDING;
					s.phase = PH_SKIP;
				end
			end
			PH_AFTER_LF: begin
				if (s.fault == FC_NONE) s.fault = FC_ENDING;
				s.phase = PH_SKIP;
			end
			default: begin
			end
		endcase

		cause = s.fault;
		if (cause == FC_NONE) begin
			if (s.phase == PH_BODY || s.phase == PH_DOLLAR) cause = FC_STAR;
			else if (s.phase == PH_HEX_HI || s.phase == PH_HEX_LO) cause = FC_HEX;
			else if (s.rx != s.crc) cause = FC_CRC;
		end

		res.frame_ok     = (cause == FC_NONE);
		res.crc_received = (cause == FC_HEX || cause == FC_STAR || cause == FC_DOLLAR) ?
			8'h00 : s.rx;
		res.crc_computed = s.crc;
		res.fault_cause  = cause;

		if (last_byte) begin
			nxt.phase = PH_DOLLAR;
			nxt.crc   = 8'h00;
			nxt.rx    = 8'h00;
			nxt.fault = FC_NONE;
		end else begin
			nxt = s;
		end
	end

endmodule
`default_nettype wire

[rtl/sentence_crc8_checker_unit.sv]
`default_nettype none
// Checks '$'-framed text sentences with a two-hex-digit CRC-8 (poly 0x07) after
// the '*', optional CR/LF, end marked by tlast. Takes one byte beat per cycle;
// the sentence state advances by a combinational CRC-8 byte update between the
// input register and the state/result registers. The last byte passes the
// input register, then its verdict loads the result register; the beat can
// wait on m_tready while the next sentence streams in; input stalls only when
// a finished sentence finds the result register still full.
module sentence_crc8_checker_unit import scc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // [7:0] byte_in
	input  wire logic                  s_tlast,  // last_byte
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [0] frame_ok, [8:1] crc_received, [16:9] crc_computed, [19:17] fault_cause,
	// [23:20] zero
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_nxt;
	res_t       res_nxt;
	res_t       res_q;
	logic       out_valid_q;
	logic       adv;
	logic       out_load;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign out_load = adv && last_s1;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	scc_step u_step (
		.cur       (state_q),
		.byte_in   (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_DOLLAR, crc: 8'h00, rx: 8'h00, fault: FC_NONE};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) res_q <= res_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, res_q.fault_cause, res_q.crc_computed,
		res_q.crc_received, res_q.frame_ok};

	a_ok_matches_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[19:17] == FC_NONE)))
		else $error("frame_ok disagrees with fault_cause");

	a_ok_crc_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] == m_tdata[16:9]))
		else $error("pass reported with differing CRC values");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q.phase == PH_DOLLAR && state_q.fault == FC_NONE &&
			state_q.crc == 8'h00))
		else $error("sentence state not cleared after last byte");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !out_load)
		else $error("pending result overwritten");

endmodule
`default_nettype wire

[bench/sentence_crc8_checker_unit_tb.sv]
module sentence_crc8_checker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scc_pkg::*;

	localparam int RUN_LIMIT    = 200000;
	localparam int RAND_BYTES   = 950;
	localparam int BURST_FRAMES = 30;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	sentence_crc8_checker_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// sentence tracker
	logic [2:0] trk_phase = PH_DOLLAR;
	logic [7:0] trk_crc = 8'h00;
	logic [7:0] trk_rx = 8'h00;
	logic [2:0] trk_fault = FC_NONE;
	res_t       pend_verdicts[$];

	logic [7:0] frame_buf[$];
	bit         no_idle = 1'b0;
	int         errors = 0;
	int         bytes_sent = 0;
	int         frames_sent = 0;
	int         verdicts_seen = 0;
	int         cycles = 0;
	int         cause_seen[8];

	always #5 clk = ~clk;

	function automatic logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	// -1 when not a hex digit
	function automatic int digit_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic void note_fault(logic [2:0] cause);
		if (trk_fault == FC_NONE) trk_fault = cause;
		trk_phase = PH_SKIP;
	endfunction

	function automatic void track_byte(logic [7:0] c, logic lst);
		int         v;
		res_t       r;
		logic [2:0] cause;
		v = digit_value(c);
		case (trk_phase)
			PH_DOLLAR: begin
				if (c == CH_DOLLAR) trk_phase = PH_BODY;
				else note_fault(FC_DOLLAR);
			end
			PH_BODY: begin
				if (c == CH_STAR) trk_phase = PH_HEX_HI;
				else trk_crc = crc_next(trk_crc, c);
			end
			PH_HEX_HI: begin
				if (v >= 0) begin
					trk_rx = {v[3:0], 4'h0};
					trk_phase = PH_HEX_LO;
				end else note_fault(FC_HEX);
			end
			PH_HEX_LO: begin
				if (v >= 0) begin
					trk_rx[3:0] = v[3:0];
					trk_phase = PH_TAIL;
				end else note_fault(FC_HEX);
			end
			PH_TAIL: begin
				if (c == CH_CR) trk_phase = PH_AFTER_CR;
				else if (c == CH_LF) trk_phase = PH_AFTER_LF;
				else note_fault(FC_ENDING);
			end
			PH_AFTER_CR: begin
				if (c == CH_LF) trk_phase = PH_AFTER_LF;
				else note_fault(FC_ENDING);
			end
			PH_AFTER_LF: note_fault(FC_ENDING);
			default: ;
		endcase
		if (!lst) return;
		cause = trk_fault;
		if (cause == FC_NONE) begin
			if (trk_phase == PH_BODY || trk_phase == PH_DOLLAR) cause = FC_STAR;
			else if (trk_phase == PH_HEX_HI || trk_phase == PH_HEX_LO) cause = FC_HEX;
			else if (trk_rx != trk_crc) cause = FC_CRC;
		end
		r.frame_ok = (cause == FC_NONE);
		r.crc_received = (cause == FC_HEX || cause == FC_STAR || cause == FC_DOLLAR) ?
			8'h00 : trk_rx;
		r.crc_computed = trk_crc;
		r.fault_cause = cause;
		pend_verdicts.push_back(r);
		trk_phase = PH_DOLLAR;
		trk_crc = 8'h00;
		trk_rx = 8'h00;
		trk_fault = FC_NONE;
	endfunction

	task automatic send_byte(logic [7:0] b, logic lst);
		while (!no_idle && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track_byte(b, lst);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
		frame_buf.delete();
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
	endfunction

	// star and two digits over frame_buf[1:]; body must not hold a star
	function automatic void seal(bit [1:0] lower, bit wrong);
		logic [7:0] crc;
		crc = 8'h00;
		for (int i = 1; i < frame_buf.size(); i++) crc = crc_next(crc, frame_buf[i]);
		if (wrong) crc ^= 8'($urandom_range(1, 255));
		frame_buf.push_back(CH_STAR);
		frame_buf.push_back(hex_char(crc[7:4], lower[1]));
		frame_buf.push_back(hex_char(crc[3:0], lower[0]));
	endfunction

	function automatic void build_sentence(bit wild);
		int         n;
		logic [7:0] b;
		frame_buf.delete();
		frame_buf.push_back(CH_DOLLAR);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		repeat (n) begin
			b = wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
			if (b == CH_STAR) b = b + 8'd1;
			frame_buf.push_back(b);
		end
		seal(2'($urandom), $urandom_range(0, 9) == 0);
		case ($urandom_range(0, 3))
			1: frame_buf.push_back(CH_CR);
			2: frame_buf.push_back(CH_LF);
			3: begin
				frame_buf.push_back(CH_CR);
				frame_buf.push_back(CH_LF);
			end
			default: ;
		endcase
	endfunction

	task automatic test_directed();
		frame_buf.push_back(8'h00);
		send_frame();
		put_text("$");
		send_frame();
		put_text("$*00");
		send_frame();
		// zero byte and dollar in body, lower case digits, CR LF
		put_text("$");
		frame_buf.push_back(8'h00);
		put_text("$");
		seal(2'b11, 1'b0);
		put_text("\r\n");
		send_frame();
		frame_buf.push_back(CH_DOLLAR);
		frame_buf.push_back(8'hFF);
		put_text("*G0");
		send_frame();
		put_text("$A");
		seal(2'b00, 1'b0);
		put_text("\nX");
		send_frame();
		put_text("$A");
		seal(2'b01, 1'b1);
		put_text("\r");
		send_frame();
		put_text("$AB*F");
		send_frame();
		put_text("$*0g");
		send_frame();
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (BURST_FRAMES) begin
			build_sentence(1'b0);
			send_frame();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_sentences();
		int stop;
		int n;
		stop = bytes_sent + RAND_BYTES;
		while (bytes_sent < stop) begin
			build_sentence($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
					0: frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
					1: begin
						n = $urandom_range(1, frame_buf.size());
						while (frame_buf.size() > n) void'(frame_buf.pop_back());
					end
					2: repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
					3: frame_buf[0] = 8'($urandom);
					default: begin
						frame_buf.delete();
						repeat ($urandom_range(1, 16)) frame_buf.push_back(8'($urandom));
					end
				endcase
			end
			send_frame();
		end
	endtask

	task automatic flag_mismatch(string what, logic [23:0] want, logic [23:0] got);
		errors++;
		if (errors <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
	endtask

	always @(posedge clk) m_tready <= no_idle || ($urandom_range(0, 99) >= 15);

	// one verdict beat per accepted handshake
	always @(posedge clk) begin
		res_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (pend_verdicts.size() == 0) begin
				flag_mismatch("verdict with none pending", 24'h0, m_tdata);
			end else begin
				due = pend_verdicts.pop_front();
				verdicts_seen++;
				cause_seen[due.fault_cause]++;
				if (m_tdata[0] !== due.frame_ok)
					flag_mismatch("frame_ok", due.frame_ok, m_tdata[0]);
				if (m_tdata[8:1] !== due.crc_received)
					flag_mismatch("crc_received", due.crc_received, m_tdata[8:1]);
				if (m_tdata[16:9] !== due.crc_computed)
					flag_mismatch("crc_computed", due.crc_computed, m_tdata[16:9]);
				if (m_tdata[19:17] !== due.fault_cause)
					flag_mismatch("fault_cause", due.fault_cause, m_tdata[19:17]);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts pending", cycles,
				pend_verdicts.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_random_sentences();
		s_tvalid <= 1'b0;
		while (pend_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d sentences in %0d bytes, %0d verdicts checked, %0d mismatches",
			frames_sent, bytes_sent, verdicts_seen, errors);
		$display("verdicts: ok %0d, dollar %0d, star %0d, hex %0d, ending %0d, crc %0d",
			cause_seen[FC_NONE], cause_seen[FC_DOLLAR], cause_seen[FC_STAR],
			cause_seen[FC_HEX], cause_seen[FC_ENDING], cause_seen[FC_CRC]);
		if (errors == 0 && pend_verdicts.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[files.f]
rtl/scc_pkg.sv
rtl/scc_step.sv
rtl/sentence_crc8_checker_unit.sv
bench/sentence_crc8_checker_unit_tb.sv
